FILE: sv/nrcs_pkg.sv
`timescale 1ns / 1ps
package nrcs_pkg;
  localparam int TILE3 = 409600;
  localparam int POS_LIMIT = 4608000;
  localparam int DIST_SCALE = 589824;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_SLOT = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_ADMIT = 2'd1;
  localparam logic [1:0] REG_RETAIN = 2'd2;
  localparam logic [1:0] REG_MOVE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_MOVE, S_CLEAR, S_SCAN, S_EVAL, S_EMIT, S_ERR
  } state_t;

  // one cell table entry: map, column, row, global flag
  typedef struct packed {
    logic [9:0] map;
    logic [5:0] x;
    logic [5:0] y;
    logic       glob;
  } cell_t;

  // gap from the tile edge on one axis, in scaled fixed steps
  function automatic logic [24:0] edge_gap(input logic signed [26:0] p3,
                                           input logic [5:0] tile);
    logic signed [27:0] lo;
    logic signed [27:0] hi;
    logic signed [27:0] a;
    logic signed [27:0] b;
    lo = 28'(signed'({1'b0, 6'd31}) - signed'({1'b0, tile})) * 28'sd409600;
    hi = lo + 28'sd409600;
    a = lo - 28'(p3);
    b = 28'(p3) - hi;
    if (a > 0) edge_gap = 25'(a);
    else if (b > 0) edge_gap = 25'(b);
    else edge_gap = '0;
  endfunction
endpackage

FILE: sv/nrcs_dist.sv
`timescale 1ns / 1ps
module nrcs_dist (
  input  logic                clk,
  input  logic                in_valid,
  input  logic [24:0]         gx,
  input  logic [24:0]         gy,
  input  logic [9:0]          radius,
  output logic [50:0]         sq_dist,
  output logic [43:0]         lim,
  output logic                out_valid
);
  import nrcs_pkg::*;
  // two stages: squares and r*r, then sums and scale
  logic [49:0] sx, sy;
  logic [19:0] rr;
  logic        v1;
  always_ff @(posedge clk) begin
    sx <= gx * gx;
    sy <= gy * gy;
    rr <= radius * radius;
    v1 <= in_valid;
    sq_dist <= sx + sy;
    lim <= 44'(rr) * 44'(DIST_SCALE);
    out_valid <= v1;
  end
endmodule

FILE: sv/nearest_region_cell_selector.sv
`timescale 1ns / 1ps
// Command-driven cell selector. Pulse start while busy is low: a load
// (operation 0) or slot write (1) is taken with no result. A query (2)
// either reports an error in the cycle after acceptance (status 2 for an
// empty table, 1 for a position beyond +-18000 units, one result) or, when
// nothing is known yet, the map changed or the point moved far enough,
// rebuilds the nearest list by scanning the first min(cell_count,
// MAX_CELLS) table entries one entry per cycle through a shared distance
// unit; then NUM_SLOTS results come on consecutive cycles marked by strobe,
// the final one with last. An unchanged query skips the scan and goes from
// the move check to the results. Results cannot be held off by the receiver.
module nearest_region_cell_selector #(
  parameter int NUM_SLOTS = 8,
  parameter int MAX_CELLS = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic [1:0]  operation,
  input  logic [12:0] entry_index,
  input  logic [3:0]  slot_number,
  input  logic        slot_occupied,
  input  logic [9:0]  cell_map,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic        cell_is_global,
  input  logic [9:0]  query_map,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  output logic        strobe,
  output logic [3:0]  rank,
  output logic [12:0] wanted_cell,
  output logic        wanted_valid,
  output logic [12:0] selected_cell,
  output logic        selected_valid,
  output logic        selected_loaded,
  output logic [1:0]  status,
  output logic        recomputed,
  output logic        last
);
  import nrcs_pkg::*;
  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // configuration
  logic [13:0] cell_count;
  logic [9:0]  admit_radius, retain_radius;
  logic [7:0]  move_limit_sq;
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count <= '0;
      admit_radius <= 10'd220;
      retain_radius <= 10'd240;
      move_limit_sq <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COUNT:  cell_count <= cfg_data;
        REG_ADMIT:  admit_radius <= cfg_data[9:0];
        REG_RETAIN: retain_radius <= cfg_data[9:0];
        REG_MOVE:   move_limit_sq <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // cell table memory
  cell_t mem [MAX_CELLS];
  cell_t rd;
  logic [AW-1:0] rd_addr;
  always_ff @(posedge clk) begin
    if (start && !busy && operation == OP_LOAD && 32'(entry_index) < MAX_CELLS)
      mem[entry_index[AW-1:0]] <= '{cell_map, cell_x, cell_y, cell_is_global};
    rd <= mem[rd_addr];
  end

  // active slots
  logic [12:0] act_cell [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] act_used;
  always_ff @(posedge clk) begin
    if (rst) act_used <= '0;
    else if (start && !busy && operation == OP_SLOT && 32'(slot_number) < NUM_SLOTS) begin
      act_used[slot_number[SW-1:0]] <= slot_occupied;
      act_cell[slot_number[SW-1:0]] <= slot_occupied ? entry_index : '0;
    end
  end
  function automatic logic held(input logic [12:0] idx, input logic [NUM_SLOTS-1:0] u,
                                input logic [12:0] c [NUM_SLOTS]);
    logic h;
    h = 1'b0;
    for (int k = 0; k < NUM_SLOTS; k++) if (u[k] && c[k] == idx) h = 1'b1;
    return h;
  endfunction

  // query state
  logic [12:0] w_cell [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] w_used;
  logic [50:0] best [NUM_SLOTS];
  logic [12:0] sel_entry;
  logic        sel_used;
  logic signed [23:0] last_x, last_y, qx, qy;
  logic [9:0]  last_map, qmap;
  logic        known, redo;
  logic [1:0]  err;
  state_t state, state_next;
  logic [14:0] cnt;
  logic [13:0] cnt_lim;
  logic [4:0]  ecnt;
  logic signed [26:0] px3, py3;
  logic signed [27:0] col, row;

  // pipeline: read -> gap/flags -> squares -> sums
  logic        p0_v, p1_v;
  logic [12:0] p0_i, p1_i, p2_i, p3_i;
  logic        p1_m;
  logic [24:0] p1_gx, p1_gy;
  logic [9:0]  p1_r;
  logic [50:0] d3;
  logic [43:0] l3;
  logic        v3;
  logic        m2, m3;

  nrcs_dist u_dist (
    .clk(clk), .in_valid(p1_v), .gx(p1_gx), .gy(p1_gy), .radius(p1_r),
    .sq_dist(d3), .lim(l3), .out_valid(v3)
  );

  // containing tile: 32 + floor(-p3 / TILE3) by compare against tile multiples
  function automatic logic signed [27:0] tile_of(input logic signed [26:0] p3);
    logic signed [27:0] t;
    t = 28'sd0;
    for (int k = -34; k <= 33; k++)
      if (-28'(p3) >= 28'(k) * 28'sd409600) t = 28'(k);
    return 28'sd32 + t;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  logic hit, hit_r;
  logic redo_now;
  logic [47:0] dx2, dy2;
  logic signed [24:0] ddx, ddy;
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start && operation == OP_QUERY) begin
        if (cell_count == 0 || pos_x > POS_LIMIT || pos_x < -POS_LIMIT ||
            pos_y > POS_LIMIT || pos_y < -POS_LIMIT) state_next = S_ERR;
        else state_next = S_MOVE;
      end
      S_MOVE:  state_next = redo_now ? S_CLEAR : S_EMIT;
      S_CLEAR: state_next = S_SCAN;
      S_SCAN:  if (cnt == 15'(cnt_lim) + 15'd5) state_next = S_EVAL;
      S_EVAL:  state_next = S_EMIT;
      S_EMIT:  if (32'(ecnt) == NUM_SLOTS - 1) state_next = S_IDLE;
      S_ERR:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
  assign busy = (state != S_IDLE);
  assign rd_addr = cnt[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      known <= 1'b0; last_x <= '0; last_y <= '0; last_map <= '0;
      w_used <= '0; sel_used <= 1'b0; sel_entry <= '0;
      p0_v <= 1'b0; p1_v <= 1'b0; cnt <= '0; ecnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (start && operation == OP_QUERY) begin
          qx <= pos_x; qy <= pos_y; qmap <= query_map;
          err <= (cell_count == 0) ? ST_EMPTY : ST_RANGE;
          ddx <= 25'(pos_x) - 25'(last_x);
          ddy <= 25'(pos_y) - 25'(last_y);
          cnt_lim <= (32'(cell_count) > MAX_CELLS) ? 14'(MAX_CELLS) : cell_count;
        end
        S_MOVE: begin
          redo <= redo_now;
          px3 <= 27'(qx) * 27'sd3;
          py3 <= 27'(qy) * 27'sd3;
          cnt <= '0;
          ecnt <= '0;
        end
        S_CLEAR: begin
          w_used <= '0; sel_used <= 1'b0; sel_entry <= '0;
          for (int k = 0; k < NUM_SLOTS; k++) begin
            best[k] <= '1; w_cell[k] <= '0;
          end
          col <= tile_of(py3); row <= tile_of(px3);
        end
        S_SCAN: begin
          cnt <= cnt + 15'd1;
          p0_i <= cnt[12:0];
          if (hit) begin sel_used <= 1'b1; sel_entry <= p1_i; end
          if (v3 && m3 && d3 <= 51'(l3)) begin
            for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
              if ((!w_used[j] || d3 < best[j]) &&
                  (j == 0 || (w_used[j-1] && !(d3 < best[j-1])))) begin
                best[j] <= d3; w_cell[j] <= p3_i; w_used[j] <= 1'b1;
              end else if (j > 0 && (!w_used[j-1] || d3 < best[j-1])) begin
                best[j] <= best[j-1]; w_cell[j] <= w_cell[j-1];
                w_used[j] <= w_used[j-1];
              end
            end
          end
        end
        S_EVAL: begin
          last_x <= qx; last_y <= qy; last_map <= qmap; known <= 1'b1;
          ecnt <= '0;
        end
        S_EMIT: ecnt <= ecnt + 5'd1;
        default: ;
      endcase
      p0_v <= (state == S_SCAN) && (cnt < 15'(cnt_lim));
      p1_v <= p0_v; p1_i <= p0_i;
    end
  end

  assign dx2 = 48'(ddx * ddx);
  assign dy2 = 48'(ddy * ddy);
  // rebuild when nothing is known yet, the map changed or the move is too large
  assign redo_now = !known || last_map != qmap ||
                    (dx2 + dy2) >= 48'({move_limit_sq, 16'd0});

  // stage after the read: map match, gaps, radius choice, containing-tile hit
  always_ff @(posedge clk) begin
    p1_m <= (rd.map == qmap);
    p1_gx <= rd.glob ? '0 : edge_gap(px3, rd.y);
    p1_gy <= rd.glob ? '0 : edge_gap(py3, rd.x);
    p1_r <= held(p0_i, act_used, act_cell) ? retain_radius : admit_radius;
    hit_r <= p0_v && (rd.map == qmap) &&
             (rd.glob || (col == 28'(rd.x) && row == 28'(rd.y)));
    p2_i <= p1_i; p3_i <= p2_i;
    m2 <= p1_v && p1_m; m3 <= m2;
  end
  assign hit = hit_r;

  // outputs
  assign strobe = (state == S_EMIT) || (state == S_ERR);
  assign rank = (state == S_EMIT) ? ecnt[3:0] : '0;
  assign wanted_valid = (state == S_EMIT) && w_used[ecnt[SW-1:0]];
  assign wanted_cell = wanted_valid ? w_cell[ecnt[SW-1:0]] : '0;
  assign selected_valid = (state == S_EMIT) && sel_used;
  assign selected_cell = selected_valid ? sel_entry : '0;
  assign selected_loaded = selected_valid && held(sel_entry, act_used, act_cell);
  assign status = (state == S_ERR) ? err : ST_OK;
  assign recomputed = (state == S_EMIT) && redo;
  assign last = (state == S_ERR) || ((state == S_EMIT) && 32'(ecnt) == NUM_SLOTS - 1);

`ifndef NO_ASSERTIONS
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe) else $error("result after last");
  a_busy_strobe: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("strobe while idle");
`endif
endmodule
